### rtl/kntok_pkg.sv
// ----------------------------------------------------------------------------
// kntok_pkg
// Shared types and constants of the keyword/number tokenizer: token kinds,
// token record, queue entry holding all tokens closed by one source byte.
// ----------------------------------------------------------------------------
`default_nettype none

package kntok_pkg;

	// Position counters (byte position, token begin, token size)
	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// Output field widths
	localparam int TOK_W   = 16;
	localparam int KIND_W  = 5;
	localparam int LINE_W  = 16;

	// Identifier prefix buffer
	localparam int WORD_DEPTH = 11;
	localparam int WB_AW      = $clog2(WORD_DEPTH);

	// Tokens one source byte can produce, and the count field
	localparam int RES_MAX = 3;
	localparam int CNT_W   = $clog2(RES_MAX + 1);
	localparam int IDX_W   = $clog2(RES_MAX);

	// Token queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Token kinds
	localparam logic [KIND_W-1:0] K_IDENT       = 5'd0;
	localparam logic [KIND_W-1:0] K_NUMBER      = 5'd1;
	localparam logic [KIND_W-1:0] K_COLON       = 5'd2;
	localparam logic [KIND_W-1:0] K_ERROR       = 5'd3;
	localparam logic [KIND_W-1:0] K_EOF         = 5'd4;
	localparam logic [KIND_W-1:0] K_RECIPE      = 5'd5;
	localparam logic [KIND_W-1:0] K_INGREDIENTS = 5'd6;
	localparam logic [KIND_W-1:0] K_STEPS       = 5'd7;
	localparam logic [KIND_W-1:0] K_END         = 5'd8;
	localparam logic [KIND_W-1:0] K_SERVE       = 5'd9;
	localparam logic [KIND_W-1:0] K_FOR         = 5'd10;
	localparam logic [KIND_W-1:0] K_AT          = 5'd11;
	localparam logic [KIND_W-1:0] K_CHOP        = 5'd12;
	localparam logic [KIND_W-1:0] K_MIX         = 5'd13;
	localparam logic [KIND_W-1:0] K_HEAT        = 5'd14;
	localparam logic [KIND_W-1:0] K_BAKE        = 5'd15;
	localparam logic [KIND_W-1:0] K_BOIL        = 5'd16;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [LINE_W-1:0] line;
		logic [TOK_W-1:0]  len;
		logic [TOK_W-1:0]  offs;
	} token_t;

	// One queue entry: tokens in slot order, count of valid slots (1..RES_MAX)
	typedef struct packed {
		logic [CNT_W-1:0]          count;
		token_t [RES_MAX-1:0]      tok;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

### rtl/kntok_front.sv
// ----------------------------------------------------------------------------
// kntok_front
// Front end: takes one source byte per transaction, classifies it, advances
// the scan state and pushes the tokens it closes as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kntok_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,     // [7:0] source_byte
	input  wire  [0:0]           s_tuser,     // [0] end_of_source
	input  kntok_pkg::q_stat_t   q_stat,
	output logic                 push,
	output kntok_pkg::entry_t    push_entry
);
	import kntok_pkg::*;

	// Scan modes
	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_IDENT = 3'd1;
	localparam logic [2:0] M_INT   = 3'd2;
	localparam logic [2:0] M_DOT   = 3'd3;
	localparam logic [2:0] M_FRAC  = 3'd4;

	localparam int WORD_BITS = 8 * WORD_DEPTH;
	localparam int KW_COUNT  = 13;

	// Keywords, left-justified in the word value
	localparam logic [WORD_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		{"RECIPE", 40'h0}, {"INGREDIENTS"}, {"STEPS", 48'h0}, {"END", 64'h0},
		{"SERVE", 48'h0}, {"serve", 48'h0}, {"for", 64'h0}, {"at", 72'h0},
		{"chop", 56'h0}, {"mix", 64'h0}, {"heat", 56'h0}, {"bake", 56'h0},
		{"boil", 56'h0}
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd11, 4'd5, 4'd3, 4'd5, 4'd5, 4'd3, 4'd2, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
	};
	localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
		K_RECIPE, K_INGREDIENTS, K_STEPS, K_END, K_SERVE, K_SERVE, K_FOR, K_AT,
		K_CHOP, K_MIX, K_HEAT, K_BAKE, K_BOIL
	};

	function automatic logic [WORD_BITS-1:0] kw_mask(input logic [3:0] len);
		kw_mask = {WORD_BITS{1'b1}} << (8 * (WORD_DEPTH - int'(len)));
	endfunction

	function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
	                                                input logic [POS_BITS-1:0] b);
		logic [POS_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	// Low 16 bits of a position value, zero-extended if narrower
	function automatic logic [TOK_W-1:0] fit16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		fit16 = w[TOK_W-1:0];
	endfunction

	logic [2:0]          mode_q;
	logic [POS_BITS-1:0] begin_q;
	logic [POS_BITS-1:0] size_q;
	logic [POS_BITS-1:0] pos_q;
	logic [LINE_W-1:0]   line_q;
	logic [7:0]          wb_q [WORD_DEPTH];

	logic [2:0]          mode_d;
	logic [POS_BITS-1:0] begin_d;
	logic [POS_BITS-1:0] size_d;
	logic [POS_BITS-1:0] pos_d;
	logic [LINE_W-1:0]   line_d;
	logic                wb_we;
	logic [WB_AW-1:0]    wb_idx;

	logic [7:0]          b;
	logic                accept;
	logic                eos, is_ws, is_lf, is_letter, is_decimal, is_colon, is_dot;
	logic                consumed;
	logic                hp0, hp1, hx;
	token_t              p0, p1, x;
	logic [WORD_BITS-1:0] word_val;
	logic [KIND_W-1:0]   word_kind;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign b        = s_tdata;

	// Byte classes
	assign eos        = s_tuser[0] || (b == 8'h00);
	assign is_ws      = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D);
	assign is_lf      = (b == 8'h0A);
	assign is_decimal = (b >= 8'h30) && (b <= 8'h39);
	assign is_letter  = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
	                    || (b == 8'h5F);
	assign is_colon   = (b == 8'h3A);
	assign is_dot     = (b == 8'h2E);

	// Keyword lookup over the buffered identifier prefix
	always_comb begin
		for (int i = 0; i < WORD_DEPTH; i++) begin
			word_val[8*(WORD_DEPTH-1-i) +: 8] = wb_q[i];
		end
		word_kind = K_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			if ((size_q == POS_BITS'(KW_LEN[k])) &&
			    (((word_val ^ KW_TEXT[k]) & kw_mask(KW_LEN[k])) == '0)) begin
				word_kind = KW_KIND[k];
			end
		end
	end

	// Does the current token absorb this byte
	always_comb begin
		case (mode_q)
			M_IDENT: consumed = is_letter || is_decimal;
			M_INT:   consumed = is_decimal || is_dot;
			M_DOT:   consumed = is_decimal;
			M_FRAC:  consumed = is_decimal;
			default: consumed = 1'b0;
		endcase
		if (eos) begin
			consumed = 1'b0;
		end
	end

	// Tokens closed by this byte: pending token, dot error, byte's own token
	always_comb begin
		p0.kind = (mode_q == M_IDENT) ? word_kind : K_NUMBER;
		p0.offs = fit16(begin_q);
		p0.len  = fit16(size_q);
		p0.line = line_q;
		p1.kind = K_ERROR;
		p1.offs = fit16(sat_add(begin_q, size_q));
		p1.len  = TOK_W'(1);
		p1.line = line_q;
		x.offs  = fit16(pos_q);
		x.line  = line_q;
		hp0     = (mode_q != M_IDLE) && !consumed;
		hp1     = (mode_q == M_DOT) && !consumed;
		if (eos) begin
			hx     = 1'b1;
			x.kind = K_EOF;
			x.len  = '0;
		end else begin
			hx     = !consumed && !(is_ws || is_lf || is_letter || is_decimal);
			x.kind = is_colon ? K_COLON : K_ERROR;
			x.len  = TOK_W'(1);
		end
	end

	always_comb begin
		push_entry.count  = CNT_W'(hp0) + CNT_W'(hp1) + CNT_W'(hx);
		push_entry.tok[0] = hp0 ? p0 : x;
		push_entry.tok[1] = hp1 ? p1 : x;
		push_entry.tok[2] = x;
	end

	assign push = accept && (hp0 || hp1 || hx);

	// Next scan state
	always_comb begin
		mode_d  = mode_q;
		begin_d = begin_q;
		size_d  = size_q;
		pos_d   = sat_add(pos_q, POS_BITS'(1));
		line_d  = line_q;
		wb_we   = 1'b0;
		wb_idx  = size_q[WB_AW-1:0];
		if (eos) begin
			mode_d  = M_IDLE;
			begin_d = '0;
			size_d  = '0;
			pos_d   = '0;
			line_d  = LINE_W'(1);
		end else if (consumed) begin
			case (mode_q)
				M_IDENT: begin
					wb_we  = size_q < POS_BITS'(WORD_DEPTH);
					size_d = sat_add(size_q, POS_BITS'(1));
				end
				M_INT: begin
					if (is_dot) begin
						mode_d = M_DOT;
					end else begin
						size_d = sat_add(size_q, POS_BITS'(1));
					end
				end
				M_DOT: begin
					mode_d = M_FRAC;
					size_d = sat_add(size_q, POS_BITS'(2));
				end
				default: begin
					size_d = sat_add(size_q, POS_BITS'(1));
				end
			endcase
		end else begin
			mode_d = M_IDLE;
			if (is_lf) begin
				if (line_q != {LINE_W{1'b1}}) begin
					line_d = line_q + LINE_W'(1);
				end
			end else if (is_letter || is_decimal) begin
				mode_d  = is_letter ? M_IDENT : M_INT;
				begin_d = pos_q;
				size_d  = POS_BITS'(1);
				wb_we   = is_letter;
				wb_idx  = '0;
			end
		end
	end

	// Scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			begin_q <= '0;
			size_q  <= '0;
			pos_q   <= '0;
			line_q  <= LINE_W'(1);
		end else if (accept) begin
			mode_q  <= mode_d;
			begin_q <= begin_d;
			size_q  <= size_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
		end
	end

	// Identifier prefix buffer, no reset
	always_ff @(posedge clk) begin
		if (accept && wb_we) begin
			wb_q[wb_idx] <= b;
		end
	end

endmodule

`default_nettype wire

### rtl/kntok_queue.sv
// ----------------------------------------------------------------------------
// kntok_queue
// Short FIFO of token groups between the front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kntok_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  kntok_pkg::entry_t    push_entry,
	input  wire                  pop,
	output kntok_pkg::entry_t    head,
	output kntok_pkg::q_stat_t   q_stat
);
	import kntok_pkg::*;

	entry_t           slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (QAW+1)'(QDEPTH));
	assign q_stat.empty = (count_q == '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

### rtl/kntok_back.sv
// ----------------------------------------------------------------------------
// kntok_back
// Output stage: walks the tokens of the head queue entry one per cycle into
// an output register whenever it is free or draining, marks the last token of each source byte.
// ----------------------------------------------------------------------------
`default_nettype none

module kntok_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  kntok_pkg::entry_t    head,
	input  kntok_pkg::q_stat_t   q_stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [47:0]          m_tdata,     // [15:0] token_offset, [31:16] token_length,
	                                          // [47:32] token_line
	output logic [4:0]           m_tuser,     // [4:0] token_kind
	output logic                 m_tlast      // last_token
);
	import kntok_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	token_t           out_tok_q;
	logic             out_last_q;

	logic             load;
	logic             is_last;

	// Load the next token whenever the output register is free or draining
	assign load    = !q_stat.empty && (!out_valid_q || m_tready);
	assign is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == head.count);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_last ? '0 : idx_q + IDX_W'(1);
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q  <= head.tok[idx_q];
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_tok_q.line, out_tok_q.len, out_tok_q.offs};
	assign m_tuser  = out_tok_q.kind;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

### rtl/keyword_number_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// keyword_number_tokenizer_unit
// Byte-serial lexer for identifiers, keywords, numbers and colons.
// Throughput: one source byte per cycle while the token queue has room; the
//   output port delivers at most one token per cycle, so runs of bytes that
//   close several tokens each stall input once the four-entry queue fills.
// Path: a byte's tokens are registered in a queue entry, then in the
//   output register; later tokens follow one per cycle while m_tready is high.
// Reset: arst_n clears scan state (line 1, position 0), queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_number_tokenizer_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,     // [7:0] source_byte
	input  wire  [0:0]  s_tuser,     // [0] end_of_source
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,     // [15:0] token_offset, [31:16] token_length,
	                                 // [47:32] token_line
	output logic [4:0]  m_tuser,     // [4:0] token_kind
	output logic        m_tlast      // last_token
);
	import kntok_pkg::*;

	logic    push;
	logic    pop;
	entry_t  push_entry;
	entry_t  head;
	q_stat_t q_stat;

	kntok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	kntok_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	kntok_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// Front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("token queue overflow");

	// Back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty) else $error("token queue underflow");

	// End of source always produces at least the eof token
	a_eos_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] || (s_tdata == 8'h00))) |-> push)
		else $error("end of source produced no tokens");

	// Every queued group holds one to three tokens
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((push_entry.count != '0) &&
		          (push_entry.count <= CNT_W'(RES_MAX))))
		else $error("bad token group count");
`endif

endmodule

`default_nettype wire

### dv/keyword_number_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// keyword_number_tokenizer_unit_tb
// Self-checking bench for the byte-serial keyword/number tokenizer. Source
// bytes go in over the slave stream with random gaps. A bit-level predictor
// of the scanner computes the tokens each accepted byte closes. Every token
// transaction on the master stream is checked against the oldest prediction.
// Covers directed corner cases, the keyword set and random recipe-like text.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_number_tokenizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kntok_pkg::*;

	// Scanner modes of the predictor
	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_WORD,
		SCAN_INT,
		SCAN_DOT,
		SCAN_FRAC
	} scan_mode_e;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [TOK_W-1:0]  offs;
		logic [TOK_W-1:0]  len;
		logic [LINE_W-1:0] line;
		logic              last;
	} token_rec_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
	localparam int DRAIN_CYCLES = 6;

	// Keyword spellings and their token kinds
	string kw_names [13] = '{"RECIPE", "INGREDIENTS", "STEPS", "END", "SERVE", "serve",
		"for", "at", "chop", "mix", "heat", "bake", "boil"};
	logic [KIND_W-1:0] kw_kinds [13] = '{K_RECIPE, K_INGREDIENTS, K_STEPS, K_END, K_SERVE,
		K_SERVE, K_FOR, K_AT, K_CHOP, K_MIX, K_HEAT, K_BAKE, K_BOIL};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] source_byte
	logic [0:0]  s_tuser;   // [0] end_of_source
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // [15:0] token_offset, [31:16] token_length, [47:32] token_line
	logic [4:0]  m_tuser;   // [4:0] token_kind
	logic        m_tlast;   // last_token

	keyword_number_tokenizer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	scan_mode_e          mode;
	logic [POS_BITS-1:0] tok_begin;
	logic [POS_BITS-1:0] tok_size;
	logic [POS_BITS-1:0] pos_now;
	logic [LINE_W-1:0]   line_now;
	logic [7:0]          word_buf [WORD_DEPTH];

	token_rec_t tok_expected [$];
	token_rec_t step_toks [$];

	// Run control and statistics
	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;
	int errors = 0;
	int bytes_sent = 0;
	int tokens_checked = 0;
	int eof_seen = 0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
			input longint k);
		longint s;
		s = longint'(a) + k;
		return (s > longint'(POS_MAX)) ? POS_MAX : s[POS_BITS-1:0];
	endfunction

	function automatic bit is_word_start(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_decimal(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [KIND_W-1:0] word_kind();
		bit hit;
		for (int i = 0; i < 13; i++) begin
			if (tok_size == kw_names[i].len()) begin
				hit = 1'b1;
				for (int j = 0; j < kw_names[i].len(); j++)
					if (word_buf[j] != kw_names[i][j]) hit = 1'b0;
				if (hit) return kw_kinds[i];
			end
		end
		return K_IDENT;
	endfunction

	task automatic add_token(input logic [KIND_W-1:0] kind, input logic [POS_BITS-1:0] offs,
			input logic [POS_BITS-1:0] len);
		token_rec_t t;
		t.kind = kind;
		t.offs = offs[TOK_W-1:0];
		t.len  = len[TOK_W-1:0];
		t.line = line_now;
		t.last = 1'b0;
		step_toks.push_back(t);
	endtask

	task automatic reset_scan();
		mode      = SCAN_IDLE;
		tok_begin = '0;
		tok_size  = '0;
		pos_now   = '0;
		line_now  = 1;
	endtask

	// Emit the token in progress, if any
	task automatic close_token();
		case (mode)
		SCAN_WORD: add_token(word_kind(), tok_begin, tok_size);
		SCAN_INT, SCAN_FRAC: add_token(K_NUMBER, tok_begin, tok_size);
		SCAN_DOT: begin
			add_token(K_NUMBER, tok_begin, tok_size);
			add_token(K_ERROR, sat_add(tok_begin, tok_size), 1);
		end
		default: ;
		endcase
		mode = SCAN_IDLE;
	endtask

	// Byte seen between tokens
	task automatic start_token(input logic [7:0] b);
		if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
			return;
		end else if (b == CH_LF) begin
			if (line_now < LINE_MAX) line_now++;
		end else if (is_word_start(b)) begin
			mode        = SCAN_WORD;
			tok_begin   = pos_now;
			tok_size    = 1;
			word_buf[0] = b;
		end else if (is_decimal(b)) begin
			mode      = SCAN_INT;
			tok_begin = pos_now;
			tok_size  = 1;
		end else if (b == CH_COLON) begin
			add_token(K_COLON, pos_now, 1);
		end else begin
			add_token(K_ERROR, pos_now, 1);
		end
	endtask

	// Tokens closed by one accepted source byte
	task automatic predict_tokens(input logic [7:0] b, input logic eos);
		bit taken;
		step_toks.delete();
		if (eos || b == CH_NUL) begin
			close_token();
			add_token(K_EOF, pos_now, 0);
			reset_scan();
		end else begin
			taken = 1'b0;
			case (mode)
			SCAN_WORD: if (is_word_start(b) || is_decimal(b)) begin
				if (tok_size < WORD_DEPTH) word_buf[tok_size] = b;
				tok_size = sat_add(tok_size, 1);
				taken = 1'b1;
			end
			SCAN_INT: if (is_decimal(b)) begin
				tok_size = sat_add(tok_size, 1);
				taken = 1'b1;
			end else if (b == CH_DOT) begin
				mode  = SCAN_DOT;
				taken = 1'b1;
			end
			SCAN_DOT: if (is_decimal(b)) begin
				tok_size = sat_add(tok_size, 2);
				mode  = SCAN_FRAC;
				taken = 1'b1;
			end
			SCAN_FRAC: if (is_decimal(b)) begin
				tok_size = sat_add(tok_size, 1);
				taken = 1'b1;
			end
			default: ;
			endcase
			if (!taken) begin
				close_token();
				start_token(b);
			end
			pos_now = sat_add(pos_now, 1);
		end
		if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
		foreach (step_toks[i]) tok_expected.push_back(step_toks[i]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One source transaction on the slave stream
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= eos;
		do @(posedge clk); while (!s_tready);
		predict_tokens(b, eos);
		bytes_sent++;
		if (eos || b == CH_NUL) eof_seen++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	// Sender holds off until every predicted token has come out
	task automatic pause_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tok_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_word_char(input bit first);
		string head;
		string tail;
		head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		tail = "0123456789";
		if (first || $urandom_range(0, 3) != 0) return head[$urandom_range(0, head.len()-1)];
		return tail[$urandom_range(0, 9)];
	endfunction

	task automatic send_digits(input int n);
		for (int i = 0; i < n; i++) send_byte("0" + $urandom_range(0, 9), 1'b0);
	endtask

	task automatic send_separator();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: send_byte(CH_SPACE, 1'b0);
		4: send_byte(CH_TAB, 1'b0);
		5: send_byte(CH_CR, 1'b0);
		6: send_byte(CH_LF, 1'b0);
		default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Whitespace, numbers with and without fraction, dots, odd bytes, both EOF forms
	task automatic test_directed_cases();
		send_byte(CH_NUL, 1'b0);           // empty source
		send_text("a1 42:3.25.\t7.x\r\n");
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte("@", 1'b0);
		send_text("5.");
		send_byte(8'h7F, 1'b1);            // flagged end, dot still pending
		send_text("_Z");
		send_byte(CH_NUL, 1'b0);
	endtask

	// Every keyword, then an identifier longer than the prefix buffer
	task automatic test_keyword_set();
		for (int i = 0; i < 13; i++) begin
			send_text(kw_names[i]);
			case ($urandom_range(0, 3))
			0: send_byte(CH_SPACE, 1'b0);
			1: send_byte(CH_COLON, 1'b0);
			2: send_byte(CH_LF, 1'b0);
			default: send_byte(CH_TAB, 1'b0);
			endcase
		end
		send_text("INGREDIENTSX");
		send_byte(CH_SPACE, 1'b0);
		send_text("at");
		send_byte($urandom_range(0, 255), 1'b1);
	endtask

	// Recipe-like text with random content, plus noise and broken numbers
	task automatic test_random_recipes();
		int first_byte;
		bit paused;
		int r;
		first_byte = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - first_byte < 12) begin
			if (!paused && bytes_sent - first_byte >= 6) begin
				pause_until_drained();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 25) begin
				send_text(kw_names[$urandom_range(0, 12)]);
			end else if (r < 45) begin
				send_byte(rand_word_char(1'b1), 1'b0);
				repeat ($urandom_range(0, 13)) send_byte(rand_word_char(1'b0), 1'b0);
			end else if (r < 65) begin
				send_digits($urandom_range(1, 4));
				case ($urandom_range(0, 5))
				0, 1: begin
					send_byte(CH_DOT, 1'b0);
					send_digits($urandom_range(1, 3));
				end
				2: send_byte(CH_DOT, 1'b0);      // dangling dot
				3: begin
					send_text("5.");
					send_digits(1);
					send_byte(CH_DOT, 1'b0);     // dot after a fraction
				end
				default: ;
				endcase
			end else if (r < 72) begin
				send_byte(CH_COLON, 1'b0);
			end else if (r < 80) begin
				send_byte(CH_LF, 1'b0);
			end else if (r < 92) begin
				send_byte($urandom_range(0, 255), 1'b0);
			end else begin
				send_byte($urandom_range(0, 255), 1'b1);
			end
			send_separator();
		end
		send_byte(CH_NUL, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Master side: random backpressure
	// ------------------------------------------------------------------
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!stalls_on) begin
				m_tready <= 1'b1;
			end else if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				hold = pick_gap();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check each token transaction against the oldest prediction
	always @(posedge clk) begin
		token_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			tokens_checked++;
			if (tok_expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected token kind=%0d offs=%0d len=%0d line=%0d last=%0b",
						$realtime, m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
						m_tlast);
			end else begin
				want = tok_expected.pop_front();
				if (m_tuser !== want.kind || m_tdata[15:0] !== want.offs ||
						m_tdata[31:16] !== want.len || m_tdata[47:32] !== want.line ||
						m_tlast !== want.last) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: token mismatch exp kind=%0d offs=%0d len=%0d line=%0d last=%0b",
							$realtime, want.kind, want.offs, want.len, want.line, want.last);
						$display("    got kind=%0d offs=%0d len=%0d line=%0d last=%0b",
							m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		reset_scan();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_keyword_set();
		pause_until_drained();
		test_random_recipes();
		pause_until_drained();

		$display("Run covered %0d source bytes, %0d end-of-source events, %0d tokens checked",
			bytes_sent, eof_seen, tokens_checked);
		$display("Scenarios: corner cases, keyword set, random recipe text");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d token errors", errors);
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("Timeout with %0d tokens still expected", tok_expected.size());
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
